/* src/csq_pkg.sv */
// Shared types and codes for the cursor sequence store.
package csq_pkg;

   typedef enum logic [2:0] {
      REQ_START   = 3'd0,
      REQ_ADVANCE = 3'd1,
      REQ_INSERT  = 3'd2,
      REQ_ATTACH  = 3'd3,
      REQ_REMOVE  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_NO_CURRENT = 2'd1,
      ERR_FULL       = 2'd2
   } err_code_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic open_gap;
      logic close_gap;
   } cell_cmd_type;

   // Tells the top level how to form the response word.
   typedef struct packed {
      logic         use_new;
      logic         has_current;
      err_code_type err;
   } read_info_type;

endpackage

/* src/csq_req_if.sv */
// Request channel interface: valid, ready and the request word.
interface csq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] entry_value;

   modport source (output valid, output req_type, output entry_value, input ready);
   modport sink (input valid, input req_type, input entry_value, output ready);
endinterface

/* src/csq_rsp_if.sv */
// Response channel interface: valid, ready and the status word.
interface csq_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] current_value;
   logic        has_current;
   logic [5:0]  item_count;
   logic [1:0]  error_code;

   modport source (output valid, output current_value, output has_current,
                   output item_count, output error_code, input ready);
   modport sink (input valid, input current_value, input has_current,
                 input item_count, input error_code, output ready);
endinterface

/* src/cursor_sequence_store.sv */
// A response word is registered when its request word is taken and is offered in the cycle after.
// Throughput: one request word per cycle while rsp takes each response word; the cells shift in the accept cycle.
// A response word that waits on rsp holds off the request side until rsp takes it.
// Reset clears the item count, the cursor and the response valid; entries are not
// cleared and only positions below the item count are ever read.
module cursor_sequence_store #(
   parameter int CAPACITY = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   csq_req_if.sink     req_ch,
   csq_rsp_if.source   rsp_ch
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic                   fire;
   logic [DATA_WIDTH-1:0]  new_value;
   logic [DATA_WIDTH-1:0]  cell_value [CAPACITY];
   logic [DATA_WIDTH-1:0]  rd_value;
   csq_pkg::cell_cmd_type  cmd;
   csq_pkg::read_info_type info;
   logic [IW-1:0]          pos;
   logic [IW-1:0]          rd_idx;
   logic [CW-1:0]          total_next;

   logic                   rsp_valid_ff;
   logic [31:0]            current_value_ff;
   logic                   has_current_ff;
   logic [5:0]             item_count_ff;
   logic [1:0]             error_code_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;
   assign new_value    = DATA_WIDTH'(req_ch.entry_value);

   csq_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .req_type   (req_ch.req_type),
      .cmd        (cmd),
      .pos        (pos),
      .rd_idx     (rd_idx),
      .info       (info),
      .total_next (total_next)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_value;
      logic [DATA_WIDTH-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = cell_value[i];
      end else begin : g_mid_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_mid_right
         assign right_value = cell_value[i+1];
      end

      csq_cell #(
         .INDEX      (i),
         .IDX_WIDTH  (IW),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (pos),
         .new_value   (new_value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i])
      );
   end

   always_comb begin
      if (info.use_new) begin
         rd_value = new_value;
      end else if (info.has_current) begin
         rd_value = cell_value[rd_idx];
      end else begin
         rd_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         current_value_ff <= 32'(rd_value);
         has_current_ff   <= info.has_current;
         item_count_ff    <= 6'(total_next);
         error_code_ff    <= info.err;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.current_value = current_value_ff;
   assign rsp_ch.has_current   = has_current_ff;
   assign rsp_ch.item_count    = item_count_ff;
   assign rsp_ch.error_code    = error_code_ff;

endmodule

/* src/csq_cell.sv */
// One entry of the store; loads, holds or takes a neighbor's value.
module csq_cell #(
   parameter int INDEX = 0,
   parameter int IDX_WIDTH = 5,
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  csq_pkg::cell_cmd_type   cmd,
   input  logic [IDX_WIDTH-1:0]    pos,
   input  logic [DATA_WIDTH-1:0]   new_value,
   input  logic [DATA_WIDTH-1:0]   left_value,
   input  logic [DATA_WIDTH-1:0]   right_value,
   output logic [DATA_WIDTH-1:0]   value
);

   localparam logic [IDX_WIDTH-1:0] MY_INDEX = IDX_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.open_gap) begin
         if (MY_INDEX > pos) begin
            value_in = left_value;
         end else if (MY_INDEX == pos) begin
            value_in = new_value;
         end
      end else if (cmd.close_gap) begin
         if (MY_INDEX >= pos) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* src/csq_ctrl.sv */
// Cursor and item count registers; decodes a request into a row command.
module csq_ctrl #(
   parameter int CAPACITY = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [2:0]                      req_type,
   output csq_pkg::cell_cmd_type           cmd,
   output logic [$clog2(CAPACITY)-1:0]     pos,
   output logic [$clog2(CAPACITY)-1:0]     rd_idx,
   output csq_pkg::read_info_type          info,
   output logic [$clog2(CAPACITY+1)-1:0]   total_next
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW:0]   cursor_inc;
   logic          have;
   logic          full;
   logic          next_has;
   csq_pkg::cell_cmd_type row_cmd;

   assign cursor_inc = (CW + 1)'(cursor_ff) + 1'b1;
   assign have       = cursor_ff < total_ff;
   assign full       = total_ff == CW'(CAPACITY);
   assign next_has   = cursor_inc < (CW + 1)'(total_ff);

   always_comb begin
      total_in         = total_ff;
      cursor_in        = cursor_ff;
      row_cmd          = '0;
      pos              = IW'(cursor_ff);
      rd_idx           = IW'(cursor_ff);
      info.use_new     = 1'b0;
      info.has_current = have;
      info.err         = csq_pkg::ERR_NONE;
      unique case (csq_pkg::req_code_type'(req_type))
         csq_pkg::REQ_START: begin
            cursor_in        = '0;
            rd_idx           = '0;
            info.has_current = total_ff != '0;
         end
         csq_pkg::REQ_ADVANCE: begin
            if (!have) begin
               info.err = csq_pkg::ERR_NO_CURRENT;
            end else begin
               cursor_in        = CW'(cursor_inc);
               rd_idx           = IW'(cursor_inc);
               info.has_current = next_has;
            end
         end
         csq_pkg::REQ_INSERT: begin
            if (full) begin
               info.err = csq_pkg::ERR_FULL;
            end else begin
               cursor_in        = have ? cursor_ff : '0;
               pos              = IW'(cursor_in);
               row_cmd.open_gap = 1'b1;
               total_in         = total_ff + 1'b1;
               info.use_new     = 1'b1;
               info.has_current = 1'b1;
            end
         end
         csq_pkg::REQ_ATTACH: begin
            if (full) begin
               info.err = csq_pkg::ERR_FULL;
            end else begin
               cursor_in        = have ? CW'(cursor_inc) : total_ff;
               pos              = IW'(cursor_in);
               row_cmd.open_gap = 1'b1;
               total_in         = total_ff + 1'b1;
               info.use_new     = 1'b1;
               info.has_current = 1'b1;
            end
         end
         csq_pkg::REQ_REMOVE: begin
            if (!have) begin
               info.err = csq_pkg::ERR_NO_CURRENT;
            end else begin
               // The cursor stays; the following entry slides into its place.
               row_cmd.close_gap = 1'b1;
               total_in          = total_ff - 1'b1;
               rd_idx            = IW'(cursor_inc);
               info.has_current  = next_has;
            end
         end
         default: begin
         end
      endcase
   end

   assign cmd        = fire ? row_cmd : '0;
   assign total_next = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         cursor_ff <= '0;
      end else if (fire) begin
         total_ff  <= total_in;
         cursor_ff <= cursor_in;
      end
   end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the cursor sequence store: random stimulus, shadow list, word compare.
module tb_top;

   localparam int SEQ_CAPACITY = 32;
   localparam int SEQ_DATA_WIDTH = 32;
   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 4;
   localparam logic [2:0] FIRST_UNUSED_REQ = 3'd5;
   localparam logic [2:0] LAST_UNUSED_REQ = 3'd7;

   typedef struct packed {
      logic [31:0]           value;
      logic                  has_cur;
      logic [5:0]            count;
      csq_pkg::err_code_type err;
   } store_status_type;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] value;
      int          gap;
      bit          drain_first;
   } list_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csq_req_if req_bus();
   csq_rsp_if rsp_bus();

   cursor_sequence_store #(
      .CAPACITY(SEQ_CAPACITY),
      .DATA_WIDTH(SEQ_DATA_WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   always #5 clock = ~clock;

   // Shadow copy of the list held by the block.
   logic [31:0] seq_mem [SEQ_CAPACITY];
   int seq_len = 0;
   int seq_cursor = 0;

   list_request_type pending_requests[$];
   store_status_type expected_status[$];
   int words_sent = 0;
   int words_checked = 0;
   int gap_left = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   bit mismatch_seen = 1'b0;

   function automatic store_status_type apply_request(input logic [2:0] op,
                                                      input logic [31:0] val);
      store_status_type s;
      csq_pkg::err_code_type err;
      int i;
      err = csq_pkg::ERR_NONE;
      case (op) inside
         csq_pkg::REQ_START: seq_cursor = 0;
         csq_pkg::REQ_ADVANCE: begin
            if (seq_cursor < seq_len) seq_cursor++;
            else err = csq_pkg::ERR_NO_CURRENT;
         end
         csq_pkg::REQ_INSERT, csq_pkg::REQ_ATTACH: begin
            if (seq_len >= SEQ_CAPACITY) begin
               err = csq_pkg::ERR_FULL;
            end else begin
               if (op == csq_pkg::REQ_INSERT) begin
                  if (seq_cursor >= seq_len) seq_cursor = 0;
               end else begin
                  seq_cursor = (seq_cursor < seq_len) ? seq_cursor + 1 : seq_len;
               end
               for (i = seq_len; i > seq_cursor; i--) seq_mem[i] = seq_mem[i - 1];
               seq_mem[seq_cursor] = val;
               seq_len++;
            end
         end
         csq_pkg::REQ_REMOVE: begin
            if (seq_cursor >= seq_len) begin
               err = csq_pkg::ERR_NO_CURRENT;
            end else begin
               for (i = seq_cursor; i + 1 < seq_len; i++) seq_mem[i] = seq_mem[i + 1];
               seq_len--;
            end
         end
         default: ;
      endcase
      s.has_cur = (seq_cursor < seq_len);
      s.value = s.has_cur ? seq_mem[seq_cursor] : 32'h0;
      s.count = seq_len[5:0];
      s.err = err;
      return s;
   endfunction

   task automatic add_request(input logic [2:0] op, input logic [31:0] value,
                              input bit drain_first = 1'b0);
      list_request_type r;
      r.op = op;
      r.value = value;
      r.drain_first = drain_first;
      // The first fifth of every hundred items runs back to back.
      r.gap = ((pending_requests.size() % 100) < 20) ? 0 : $urandom_range(0, 3);
      pending_requests.push_back(r);
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // Mix of operations leaning toward growth, balance or shrinkage.
   function automatic logic [2:0] pick_op(input int lean);
      int r;
      r = $urandom_range(0, 99);
      if (r >= 97) return 3'($urandom_range(FIRST_UNUSED_REQ, LAST_UNUSED_REQ));
      case (lean)
         0: begin
            if (r < 45) return csq_pkg::REQ_INSERT;
            if (r < 85) return csq_pkg::REQ_ATTACH;
            if (r < 90) return csq_pkg::REQ_ADVANCE;
            if (r < 94) return csq_pkg::REQ_START;
            return csq_pkg::REQ_REMOVE;
         end
         1: begin
            if (r < 20) return csq_pkg::REQ_INSERT;
            if (r < 40) return csq_pkg::REQ_ATTACH;
            if (r < 60) return csq_pkg::REQ_ADVANCE;
            if (r < 72) return csq_pkg::REQ_START;
            return csq_pkg::REQ_REMOVE;
         end
         default: begin
            if (r < 45) return csq_pkg::REQ_REMOVE;
            if (r < 65) return csq_pkg::REQ_START;
            if (r < 80) return csq_pkg::REQ_ADVANCE;
            if (r < 90) return csq_pkg::REQ_INSERT;
            return csq_pkg::REQ_ATTACH;
         end
      endcase
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.req_type <= csq_pkg::REQ_START;
         req_bus.entry_value <= 32'h0;
         gap_left <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() > 0 &&
                      (!pending_requests[0].drain_first ||
                       (!req_bus.valid && words_sent == words_checked))) begin
            req_bus.valid <= 1'b1;
            req_bus.req_type <= pending_requests[0].op;
            req_bus.entry_value <= pending_requests[0].value;
            gap_left <= (pending_requests.size() > 1) ? pending_requests[1].gap : 0;
            void'(pending_requests.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response ready with random back-pressure.
   always @(posedge clock) begin : ready_gen
      int draw;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         draw = ((words_checked % 96) < 24) ? 0 : $urandom_range(0, 3);
         if (draw == 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            stall_left <= draw - 1;
         end
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Prediction on each accepted request, comparison on each accepted response.
   always @(posedge clock) begin : scoreboard
      store_status_type got;
      store_status_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_status.push_back(apply_request(req_bus.req_type, req_bus.entry_value));
            words_sent <= words_sent + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.value = rsp_bus.current_value;
            got.has_cur = rsp_bus.has_current;
            got.count = rsp_bus.item_count;
            got.err = csq_pkg::err_code_type'(rsp_bus.error_code);
            words_checked <= words_checked + 1;
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected response word, got %h", $time, got);
               mismatch_seen = 1'b1;
            end else begin
               want = expected_status.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t: current_value expected %h, got %h",
                           $time, want.value, got.value);
                  mismatch_seen = 1'b1;
               end
               if (got.has_cur !== want.has_cur) begin
                  $display("%0t: has_current expected %b, got %b",
                           $time, want.has_cur, got.has_cur);
                  mismatch_seen = 1'b1;
               end
               if (got.count !== want.count) begin
                  $display("%0t: item_count expected %0d, got %0d",
                           $time, want.count, got.count);
                  mismatch_seen = 1'b1;
               end
               if (got.err !== want.err) begin
                  $display("%0t: error_code expected %0d, got %0d",
                           $time, want.err, got.err);
                  mismatch_seen = 1'b1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [2:0] code;
      int phase;
      int n;
      bit words_missing;
      words_missing = 1'b0;

      // Empty list: no current item for advance or remove, then unused codes.
      add_request(csq_pkg::REQ_START, 32'h0);
      add_request(csq_pkg::REQ_ADVANCE, 32'h0);
      add_request(csq_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
      for (code = FIRST_UNUSED_REQ; code <= LAST_UNUSED_REQ && code >= FIRST_UNUSED_REQ;
           code++)
         add_request(code, 32'hFFFF_FFFF);
      add_request(csq_pkg::REQ_INSERT, 32'h0);
      add_request(csq_pkg::REQ_ATTACH, 32'hFFFF_FFFF);
      add_request(csq_pkg::REQ_INSERT, 32'h1234_5678);
      add_request(csq_pkg::REQ_ADVANCE, 32'h0);
      add_request(csq_pkg::REQ_ADVANCE, 32'h0);
      add_request(csq_pkg::REQ_ADVANCE, 32'h0);
      add_request(csq_pkg::REQ_ADVANCE, 32'h0);
      // Cursor is past the end here: attach goes to the end, insert to the front.
      add_request(csq_pkg::REQ_ATTACH, 32'hA5A5_A5A5);
      add_request(csq_pkg::REQ_ADVANCE, 32'h0);
      add_request(csq_pkg::REQ_INSERT, 32'h5A5A_5A5A);
      add_request(csq_pkg::REQ_START, 32'h0);
      add_request(csq_pkg::REQ_REMOVE, 32'h0);
      add_request(csq_pkg::REQ_ADVANCE, 32'h0);
      add_request(csq_pkg::REQ_ADVANCE, 32'h0);
      add_request(csq_pkg::REQ_REMOVE, 32'h0);
      add_request(csq_pkg::REQ_REMOVE, 32'h0);
      add_request(csq_pkg::REQ_START, 32'h0);

      for (phase = 0; phase < 8; phase++) begin
         add_request(pick_op(phase % 3), pick_value(), 1'b1);
         for (n = 1; n < 50; n++) add_request(pick_op(phase % 3), pick_value());
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_bus.valid) @(posedge clock);
      while (words_checked != words_sent) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_status.size() != 0) begin
         $display("%0t: %0d response words never arrived", $time, expected_status.size());
         words_missing = 1'b1;
      end
      if (!mismatch_seen && !words_missing) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
